// File: sv/nss_pkg.sv
// Shared types and constants for the naive substring search block.
package nss_pkg;

	localparam int MAX_LEN_DEF = 64;

	typedef enum logic [1:0] {
		MODE_TEXT    = 2'd0,
		MODE_PATTERN = 2'd1,
		MODE_SEARCH  = 2'd2
	} mode_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] char_value;
	} in_item_t;

	typedef struct packed {
		logic found;
		logic overflow;
	} out_item_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic append_text;
		logic append_pat;
		logic cnt_clear;
		logic k_inc;
		logic s_inc;
		logic res_load;
		logic res_found;
		logic clear_all;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic pat_empty;
		logic pat_longer;
		logic match;
		logic last_k;
		logic last_start;
	} dp_status_t;

endpackage

// File: sv/nss_stream_if.sv
// Valid/ready stream interface with a typed payload.
interface nss_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// File: sv/nss_ram.sv
// Generic single write port, single read port RAM with registered read data.
module nss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: sv/nss_datapath.sv
// Datapath: text and pattern buffers, lengths, search counters and result register.
module nss_datapath #(
	parameter int MAX_LEN = nss_pkg::MAX_LEN_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  nss_pkg::dp_cmd_t     cmd,
	input  logic [7:0]           char_value,
	output nss_pkg::dp_status_t  status,
	output logic                 found,
	output logic                 overflow
);
	import nss_pkg::*;

	localparam int LW = $clog2(MAX_LEN + 1);
	localparam int AW = $clog2(MAX_LEN);
	localparam logic [LW-1:0] FULL = LW'(MAX_LEN);

	logic [LW-1:0] tlen_q, plen_q;
	logic          ovf_q;
	logic [AW-1:0] s_q, k_q;
	logic          found_q, overflow_q;
	logic [7:0]    text_rd, pat_rd;
	logic          text_full, pat_full;
	logic [LW-1:0] taddr_sum;

	assign text_full = (tlen_q == FULL);
	assign pat_full  = (plen_q == FULL);
	assign taddr_sum = LW'(s_q) + LW'(k_q);

	nss_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_text_ram (
		.clk   (clk),
		.we    (cmd.append_text && !text_full),
		.waddr (tlen_q[AW-1:0]),
		.wdata (char_value),
		.raddr (taddr_sum[AW-1:0]),
		.rdata (text_rd)
	);

	nss_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_pat_ram (
		.clk   (clk),
		.we    (cmd.append_pat && !pat_full),
		.waddr (plen_q[AW-1:0]),
		.wdata (char_value),
		.raddr (k_q),
		.rdata (pat_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tlen_q <= '0;
			plen_q <= '0;
			ovf_q  <= 1'b0;
		end else if (cmd.clear_all) begin
			tlen_q <= '0;
			plen_q <= '0;
			ovf_q  <= 1'b0;
		end else begin
			if (cmd.append_text) begin
				if (text_full) begin
					ovf_q <= 1'b1;
				end else begin
					tlen_q <= tlen_q + 1'b1;
				end
			end
			if (cmd.append_pat) begin
				if (pat_full) begin
					ovf_q <= 1'b1;
				end else begin
					plen_q <= plen_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cnt_clear) begin
			s_q <= '0;
			k_q <= '0;
		end else if (cmd.s_inc) begin
			s_q <= s_q + 1'b1;
			k_q <= '0;
		end else if (cmd.k_inc) begin
			k_q <= k_q + 1'b1;
		end
		if (cmd.res_load) begin
			found_q    <= cmd.res_found;
			overflow_q <= ovf_q;
		end
	end

	assign status.pat_empty  = (plen_q == '0);
	assign status.pat_longer = (plen_q > tlen_q);
	assign status.match      = (text_rd == pat_rd);
	assign status.last_k     = ((LW'(k_q) + 1'b1) == plen_q);
	assign status.last_start = ((LW'(s_q) + plen_q) == tlen_q);

	assign found    = found_q;
	assign overflow = overflow_q;
endmodule

// File: sv/nss_ctrl.sv
// Controller state machine for loading and searching.
module nss_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [1:0]          mode,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  nss_pkg::dp_status_t status,
	output nss_pkg::dp_cmd_t    cmd
);
	import nss_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_READ = 4'b0010,
		S_CMP  = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   hit_q, hit_d;
	logic   out_valid_q, out_valid_d;

	always_comb begin
		state_d     = state_q;
		hit_d       = hit_q;
		out_valid_d = out_valid_q && !out_ready;
		cmd         = '0;
		in_ready    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					unique case (mode)
						MODE_TEXT: begin
							cmd.append_text = 1'b1;
						end
						MODE_PATTERN: begin
							cmd.append_pat = 1'b1;
						end
						MODE_SEARCH: begin
							cmd.cnt_clear = 1'b1;
							if (status.pat_empty) begin
								hit_d   = 1'b1;
								state_d = S_DONE;
							end else if (status.pat_longer) begin
								hit_d   = 1'b0;
								state_d = S_DONE;
							end else begin
								state_d = S_READ;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_READ: begin
				// Buffer reads issued here return in the compare state.
				state_d = S_CMP;
			end
			S_CMP: begin
				if (status.match) begin
					if (status.last_k) begin
						hit_d   = 1'b1;
						state_d = S_DONE;
					end else begin
						cmd.k_inc = 1'b1;
						state_d   = S_READ;
					end
				end else if (status.last_start) begin
					hit_d   = 1'b0;
					state_d = S_DONE;
				end else begin
					cmd.s_inc = 1'b1;
					state_d   = S_READ;
				end
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.res_load  = 1'b1;
					cmd.res_found = hit_q;
					cmd.clear_all = 1'b1;
					out_valid_d   = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			hit_q       <= hit_d;
			out_valid_q <= out_valid_d;
		end
	end

	assign out_valid = out_valid_q;
endmodule

// File: sv/naive_substring_search_top.sv
// Append bytes are accepted back to back while no search is running.
// A search runs its byte comparisons (at most (text - pattern + 1) * pattern), each a
// buffer read state and a compare state, and then loads a registered result.
// The result waits in an output register; new appends are taken while it waits.
// Reset clears the lengths, the overflow flag and the result valid; buffer contents
// are left as they are and are only read below the current lengths.
module naive_substring_search_top #(
	parameter int MAX_LEN = nss_pkg::MAX_LEN_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	nss_stream_if.sink   in_ch,
	nss_stream_if.source out_ch
);
	import nss_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;
	logic       in_ready, out_valid, found, overflow;

	nss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.mode      (in_ch.payload.mode),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ch.ready),
		.status    (status),
		.cmd       (cmd)
	);

	nss_datapath #(.MAX_LEN(MAX_LEN)) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.char_value (in_ch.payload.char_value),
		.status     (status),
		.found      (found),
		.overflow   (overflow)
	);

	assign in_ch.ready              = in_ready;
	assign out_ch.valid             = out_valid;
	assign out_ch.payload.found     = found;
	assign out_ch.payload.overflow  = overflow;
endmodule

// File: test/naive_substring_search_top_test.sv
// Self-checking testbench for the naive substring search block.
`timescale 1ns / 100ps

module naive_substring_search_top_test;
	import nss_pkg::*;

	localparam int MAX_LEN = MAX_LEN_DEF;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int ITEM_GOAL = 550;
	localparam int SEARCH_GOAL = 40;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	// Tracks the text and pattern the block should hold and the search results it owes.
	class search_scoreboard;
		logic [7:0] text_buf [MAX_LEN];
		logic [7:0] pat_buf [MAX_LEN];
		int unsigned text_len;
		int unsigned pat_len;
		bit ovf;
		out_item_t pending_results[$];
		int errors;

		function bit pattern_present();
			bit hit;
			if (pat_len == 0)
				return 1'b1;
			for (int unsigned start = 0; start + pat_len <= text_len; start++) begin
				hit = 1'b1;
				for (int unsigned k = 0; k < pat_len; k++) begin
					if (text_buf[start + k] != pat_buf[k]) begin
						hit = 1'b0;
						break;
					end
				end
				if (hit)
					return 1'b1;
			end
			return 1'b0;
		endfunction

		function void note_input(logic [1:0] mode, logic [7:0] ch);
			out_item_t res;
			case (mode)
				MODE_TEXT: begin
					if (text_len < MAX_LEN) begin
						text_buf[text_len] = ch;
						text_len++;
					end else begin
						ovf = 1'b1;
					end
				end
				MODE_PATTERN: begin
					if (pat_len < MAX_LEN) begin
						pat_buf[pat_len] = ch;
						pat_len++;
					end else begin
						ovf = 1'b1;
					end
				end
				MODE_SEARCH: begin
					res.found = pattern_present();
					res.overflow = ovf;
					pending_results.push_back(res);
					text_len = 0;
					pat_len = 0;
					ovf = 1'b0;
				end
				default: begin
				end
			endcase
		endfunction

		task report(string msg);
			$display("%0t ns: mismatch: %s", $time, msg);
			errors++;
		endtask

		task check_result(out_item_t got);
			out_item_t want;
			if (pending_results.size() == 0) begin
				report($sformatf("unexpected result found=%b overflow=%b",
					got.found, got.overflow));
				return;
			end
			want = pending_results.pop_front();
			if (got.found !== want.found)
				report($sformatf("found is %b, expected %b", got.found, want.found));
			if (got.overflow !== want.overflow)
				report($sformatf("overflow is %b, expected %b", got.overflow, want.overflow));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	int unsigned cycle_count = 0;
	int items_sent = 0;
	int searches_run = 0;
	bit steady_in = 1'b0;
	search_scoreboard sb = new();

	nss_stream_if #(.payload_t(in_item_t)) in_ch ();
	nss_stream_if #(.payload_t(out_item_t)) out_ch ();

	naive_substring_search_top #(
		.MAX_LEN(MAX_LEN)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("== FAIL ==");
			$finish;
		end
	end

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(11, 40);
	endfunction

	function automatic logic [7:0] draw_byte(bit narrow, logic [7:0] base);
		if (narrow)
			return base + 8'($urandom_range(0, 1));
		return 8'($urandom_range(0, 255));
	endfunction

	// Presents one transaction, waits for it to be taken, then may idle for a random gap.
	task automatic push_item(input logic [1:0] mode, input logic [7:0] ch);
		int gap;
		in_ch.valid <= 1'b1;
		in_ch.payload.mode <= mode;
		in_ch.payload.char_value <= ch;
		do
			@(posedge clk);
		while (!in_ch.ready);
		sb.note_input(mode, ch);
		if (mode != MODE_UNUSED)
			items_sent++;
		if (mode == MODE_SEARCH)
			searches_run++;
		gap = steady_in ? 0 : pick_gap();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// kind 0 is a random case, 1 overfills the text, 2 overfills the pattern.
	task automatic run_sequence(input int kind);
		int tlen;
		int stored;
		int start;
		int r;
		int order;
		bit narrow;
		bit pick_text;
		logic [7:0] base;
		logic [7:0] txt[$];
		logic [7:0] pat[$];
		narrow = $urandom_range(0, 1);
		base = 8'($urandom_range(0, 255));
		steady_in = ($urandom_range(0, 4) == 0);

		r = $urandom_range(0, 99);
		if (kind == 1)
			tlen = $urandom_range(MAX_LEN + 1, MAX_LEN + 6);
		else if (r < 80)
			tlen = $urandom_range(0, 10);
		else if (r < 95)
			tlen = $urandom_range(11, 30);
		else
			tlen = $urandom_range(MAX_LEN - 4, MAX_LEN + 6);
		repeat (tlen) txt.push_back(draw_byte(narrow, base));
		stored = (tlen < MAX_LEN) ? tlen : MAX_LEN;

		r = $urandom_range(0, 99);
		if (kind == 2) begin
			repeat ($urandom_range(MAX_LEN + 1, MAX_LEN + 6))
				pat.push_back(draw_byte(narrow, base));
		end else if (r < 45 && stored > 0) begin
			// A piece of the stored text, so the pattern is there to be found.
			start = $urandom_range(0, stored - 1);
			repeat ($urandom_range(1, (stored - start < 12) ? stored - start : 12)) begin
				pat.push_back(txt[start]);
				start++;
			end
		end else if (r < 55) begin
		end else if (r < 65) begin
			repeat (stored + $urandom_range(1, 3)) pat.push_back(draw_byte(narrow, base));
		end else if (r < 97) begin
			repeat ($urandom_range(1, 6)) pat.push_back(draw_byte(narrow, base));
		end else begin
			repeat ($urandom_range(MAX_LEN - 2, MAX_LEN + 4))
				pat.push_back(draw_byte(narrow, base));
		end

		order = $urandom_range(0, 9);
		while (txt.size() != 0 || pat.size() != 0) begin
			if (order < 7)
				pick_text = (txt.size() != 0);
			else if (order < 9)
				pick_text = (pat.size() == 0) || (txt.size() != 0 && $urandom_range(0, 1));
			else
				pick_text = (pat.size() == 0);
			if (pick_text)
				push_item(MODE_TEXT, txt.pop_front());
			else
				push_item(MODE_PATTERN, pat.pop_front());
			if ($urandom_range(0, 99) < 3)
				push_item(MODE_UNUSED, 8'($urandom_range(0, 255)));
		end
		// Now and then the search is left out, so the next case piles on top.
		if (kind != 0 || $urandom_range(0, 99) >= 8)
			push_item(MODE_SEARCH, 8'($urandom_range(0, 255)));
	endtask

	// Result side: runs of ready high and low, sometimes a long run with no stall.
	initial begin
		int run_left;
		logic ready_next;
		run_left = 0;
		ready_next = 1'b0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_ch.valid && out_ch.ready)
				sb.check_result(out_ch.payload);
			if (run_left > 0) begin
				run_left--;
			end else if ($urandom_range(0, 2) != 0) begin
				ready_next = 1'b1;
				run_left = ($urandom_range(0, 19) == 0) ? 200 : $urandom_range(0, 15);
			end else begin
				ready_next = 1'b0;
				run_left = pick_gap();
			end
			out_ch.ready <= ready_next;
		end
	end

	initial begin
		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.payload <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty pattern on empty text is a hit.
		push_item(MODE_SEARCH, 8'h00);
		// Extreme byte values are plain characters.
		push_item(MODE_TEXT, 8'h00);
		push_item(MODE_TEXT, 8'hFF);
		push_item(MODE_PATTERN, 8'hFF);
		push_item(MODE_SEARCH, 8'hFF);
		// Pattern longer than the text cannot match.
		push_item(MODE_TEXT, 8'h61);
		push_item(MODE_TEXT, 8'h62);
		push_item(MODE_PATTERN, 8'h61);
		push_item(MODE_PATTERN, 8'h62);
		push_item(MODE_PATTERN, 8'h63);
		push_item(MODE_SEARCH, 8'h00);
		// Non-empty pattern against empty text.
		push_item(MODE_PATTERN, 8'h00);
		push_item(MODE_SEARCH, 8'hAA);
		// The unused mode must leave the text alone; empty pattern still hits.
		push_item(MODE_TEXT, 8'h55);
		push_item(MODE_UNUSED, 8'hAA);
		push_item(MODE_SEARCH, 8'h55);
		// Match only at a later offset.
		push_item(MODE_TEXT, 8'h80);
		push_item(MODE_TEXT, 8'h7F);
		push_item(MODE_TEXT, 8'h80);
		push_item(MODE_PATTERN, 8'h7F);
		push_item(MODE_PATTERN, 8'h80);
		push_item(MODE_SEARCH, 8'h01);

		run_sequence(1);
		run_sequence(2);
		while (items_sent < ITEM_GOAL || searches_run < SEARCH_GOAL)
			run_sequence(0);
		if (steady_in || in_ch.valid)
			in_ch.valid <= 1'b0;

		while (sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (sb.errors == 0 && sb.pending_results.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
